### rtl/tftp_read_transfer_control_defines.svh
// Assertion macros shared by the checker.
`ifndef TFTP_READ_TRANSFER_CONTROL_DEFINES_SVH
`define TFTP_READ_TRANSFER_CONTROL_DEFINES_SVH

// same-cycle implication
`define TRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tftp_rtc_pkg.sv
package tftp_rtc_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_BLK_BYTES = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 1'd1;

  localparam logic [15:0] BLK_BYTES_RST = 16'd512;
  localparam logic [7:0] RETRY_LIMIT_RST = 8'd5;

  localparam int unsigned InDataW = 56;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [2:0] {
    FUNC_START   = 3'd0,
    FUNC_TIMEOUT = 3'd1,
    FUNC_ACK     = 3'd2,
    FUNC_ERROR   = 3'd3,
    FUNC_OTHER   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_DATA       = 3'd1,
    ACT_OACK       = 3'd2,
    ACT_ERROR      = 3'd3,
    ACT_DONE       = 3'd4,
    ACT_PEER_ABORT = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_RETRIES   = 2'd1,
    ERR_WRONG_ACK = 2'd2
  } err_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] ack_block;
    logic [31:0] file_length;
    logic        option_pending;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] blk_num;
    logic [31:0] byte_offset;
    logic [15:0] data_length;
    err_e        error_kind;
  } out_item_t;

  typedef struct packed {
    logic        we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

### rtl/tftp_rtc_in_stage.sv
module tftp_rtc_in_stage
  import tftp_rtc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || take_i;
  assign load = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o = item_q;

endmodule

### rtl/tftp_rtc_ctrl.sv
module tftp_rtc_ctrl
  import tftp_rtc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_wr_t   cfg_i,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic [15:0] blk_bytes_q;
  logic [7:0]  retry_limit_q;

  logic        active_q, active_d;
  logic        opt_q, opt_d;
  logic [16:0] blk_q, blk_d;
  logic [31:0] off_q, off_d;
  logic [15:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [7:0]  retry_q, retry_d;

  logic [31:0] cut_src;
  logic [15:0] cut_len;
  logic [31:0] cut_rest;
  logic        ack_cur;
  logic        ack_prev;
  logic        emit;
  out_item_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_bytes_q   <= BLK_BYTES_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_BLK_BYTES:   blk_bytes_q <= cfg_i.data;
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  assign cut_src = (item_i.func == FUNC_START) ? item_i.file_length : left_q;
  assign cut_len = (cut_src < {16'd0, blk_bytes_q}) ? cut_src[15:0] : blk_bytes_q;
  assign cut_rest = cut_src - {16'd0, cut_len};
  assign ack_cur = ({1'b0, item_i.ack_block} == blk_q);
  assign ack_prev = ({2'b00, item_i.ack_block} == ({1'b0, blk_q} - 18'd1));

  always_comb begin
    active_d = active_q;
    opt_d    = opt_q;
    blk_d    = blk_q;
    off_d    = off_q;
    len_d    = len_q;
    left_d   = left_q;
    retry_d  = retry_q;
    emit     = 1'b0;
    res      = '0;
    case (item_i.func)
      FUNC_START: begin
        active_d = 1'b1;
        opt_d    = item_i.option_pending;
        blk_d    = 17'd1;
        off_d    = 32'd0;
        retry_d  = 8'd0;
        if (item_i.option_pending) begin
          len_d      = 16'd0;
          left_d     = item_i.file_length;
          res.action = ACT_OACK;
        end else begin
          len_d  = cut_len;
          left_d = cut_rest;
          emit   = 1'b1;
        end
      end
      FUNC_TIMEOUT: begin
        if (active_q) begin
          if (retry_q < retry_limit_q) begin
            retry_d = retry_q + 8'd1;
            if (opt_q) begin
              res.action = ACT_OACK;
            end else begin
              emit = 1'b1;
            end
          end else begin
            res.action     = ACT_ERROR;
            res.error_kind = ERR_RETRIES;
            active_d       = 1'b0;
            opt_d          = 1'b0;
          end
        end
      end
      FUNC_ERROR: begin
        if (active_q) begin
          res.action = ACT_PEER_ABORT;
          active_d   = 1'b0;
          opt_d      = 1'b0;
        end
      end
      FUNC_ACK: begin
        if (active_q) begin
          if (item_i.ack_block == 16'd0) begin
            if (opt_q) begin
              opt_d  = 1'b0;
              len_d  = cut_len;
              left_d = cut_rest;
              emit   = 1'b1;
            end
          end else if (opt_q) begin
            res.action     = ACT_ERROR;
            res.error_kind = ERR_WRONG_ACK;
            active_d       = 1'b0;
            opt_d          = 1'b0;
          end else if (ack_cur) begin
            if (len_q < blk_bytes_q) begin
              res.action = ACT_DONE;
              active_d   = 1'b0;
              opt_d      = 1'b0;
            end else begin
              off_d  = off_q + {16'd0, len_q};
              blk_d  = blk_q + 17'd1;
              len_d  = cut_len;
              left_d = cut_rest;
              emit   = 1'b1;
            end
          end else if (ack_prev) begin
            emit = 1'b1;
          end else begin
            res.action     = ACT_ERROR;
            res.error_kind = ERR_WRONG_ACK;
            active_d       = 1'b0;
            opt_d          = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (emit) begin
      res.action      = ACT_DATA;
      res.blk_num     = blk_d[15:0];
      res.byte_offset = off_d;
      res.data_length = len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      opt_q    <= 1'b0;
      blk_q    <= 17'd1;
      off_q    <= 32'd0;
      len_q    <= 16'd0;
      left_q   <= 32'd0;
      retry_q  <= 8'd0;
    end else if (fire_i) begin
      active_q <= active_d;
      opt_q    <= opt_d;
      blk_q    <= blk_d;
      off_q    <= off_d;
      len_q    <= len_d;
      left_q   <= left_d;
      retry_q  <= retry_d;
    end
  end

  assign result_o = res;

endmodule

### rtl/tftp_rtc_out_stage.sv
module tftp_rtc_out_stage
  import tftp_rtc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t result_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o = item_q;

endmodule

### rtl/tftp_read_transfer_control.sv
// An accepted item passes the input register, control logic and output register before m_axis.
// Unstalled: one event per cycle; input register, one pass of control logic, output register.
// Back pressure on m_axis stalls s_axis only when both registers hold an item.
// Reset (rst_ni low, asynchronous): no session, block counter 1, counters and lengths 0,
// block bytes 512, retry_limit 5, both stages empty.
module tftp_read_transfer_control
  import tftp_rtc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // ack_block[15:0], file_length[47:16], option_pending[48], zero [55:49]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // func[2:0]
  input  logic [2:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // blk_num[15:0], byte_offset[47:16], data_length[63:48], error_kind[65:64], zero [71:66]
  output logic [OutDataW-1:0] m_axis_tdata,
  // action[2:0]
  output logic [2:0]          m_axis_tuser,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  in_item_t  in_item;
  in_item_t  stage_item;
  logic      stage_valid;
  logic      out_free;
  logic      fire;
  out_item_t result;
  out_item_t out_item;
  cfg_wr_t   cfg;

  assign in_item.func           = func_e'(s_axis_tuser);
  assign in_item.ack_block      = s_axis_tdata[15:0];
  assign in_item.file_length    = s_axis_tdata[47:16];
  assign in_item.option_pending = s_axis_tdata[48];

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign fire = stage_valid && out_free;

  tftp_rtc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .take_i     (fire),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  tftp_rtc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (fire),
    .item_i   (stage_item),
    .result_o (result)
  );

  tftp_rtc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tuser = out_item.action;
  assign m_axis_tdata = {6'd0, out_item.error_kind, out_item.data_length,
                         out_item.byte_offset, out_item.blk_num};

endmodule

### rtl/tftp_rtc_checker.sv
`include "tftp_read_transfer_control_defines.svh"

module tftp_rtc_checker
  import tftp_rtc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [2:0]          m_axis_tuser
);

  `TRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `TRC_ASSERT_NOW(a_in_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output back pressure")
  `TRC_ASSERT_NOW(a_data_fields_zero, m_axis_tvalid && (m_axis_tuser != ACT_DATA), m_axis_tdata[63:0] == 64'd0, "data fields set without send data")
  `TRC_ASSERT_NOW(a_err_kind_zero, m_axis_tvalid && (m_axis_tuser != ACT_ERROR), m_axis_tdata[65:64] == ERR_NONE, "error kind set without send error")

endmodule

bind tftp_read_transfer_control tftp_rtc_checker u_checker (.*);

### tb/tftp_read_transfer_control_test.sv
module tftp_read_transfer_control_test;
  import tftp_rtc_pkg::*;

  localparam logic [2:0] FUNC_RESERVED_HI = 3'd7;
  localparam longint unsigned CYCLE_LIMIT = 64'd3_000_000;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] ack;
    logic [31:0] flen;
    logic        opt;
  } xfer_ev_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // ack_block[15:0], file_length[47:16], option_pending[48], zero [55:49]
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // func[2:0]
  logic [2:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // blk_num[15:0], byte_offset[47:16], data_length[63:48], error_kind[65:64], zero [71:66]
  logic [OutDataW-1:0] m_axis_tdata;
  // action[2:0]
  logic [2:0]          m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  tftp_read_transfer_control DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the sender state and registers
  logic        sess_on;
  logic        opt_phase;
  logic [16:0] blk_ctr;
  logic [31:0] blk_offset;
  logic [15:0] blk_len;
  logic [31:0] bytes_left;
  logic [7:0]  retries;
  logic [15:0] bsize;
  logic [7:0]  rlimit;

  xfer_ev_t  events_to_send[$];
  out_item_t sender_replies_due[$];
  logic      in_flight = 1'b0;

  int unsigned     events_queued;
  int unsigned     events_accepted;
  int unsigned     replies_seen;
  int unsigned     mismatches;
  int unsigned     settings_used;
  int unsigned     action_hits[8];
  longint unsigned cycles;

  function automatic void close_session();
    sess_on = 1'b0;
    opt_phase = 1'b0;
  endfunction

  function automatic void cut_block();
    logic [31:0] len;
    len = (bytes_left < {16'd0, bsize}) ? bytes_left : {16'd0, bsize};
    blk_len = len[15:0];
    bytes_left = bytes_left - len;
  endfunction

  function automatic out_item_t data_reply();
    out_item_t r;
    r = '0;
    r.action = ACT_DATA;
    r.blk_num = blk_ctr[15:0];
    r.byte_offset = blk_offset;
    r.data_length = blk_len;
    return r;
  endfunction

  function automatic out_item_t predict_sender_reply(xfer_ev_t ev);
    out_item_t r;
    r = '0;
    if (ev.func == FUNC_START) begin
      sess_on = 1'b1;
      opt_phase = ev.opt;
      blk_ctr = 17'd1;
      blk_offset = '0;
      blk_len = '0;
      bytes_left = ev.flen;
      retries = '0;
      if (ev.opt) begin
        r.action = ACT_OACK;
      end else begin
        cut_block();
        r = data_reply();
      end
    end else if (!sess_on || ev.func > FUNC_ERROR) begin
      r.action = ACT_NONE;
    end else if (ev.func == FUNC_TIMEOUT) begin
      if (retries < rlimit) begin
        retries = retries + 8'd1;
        if (opt_phase) begin
          r.action = ACT_OACK;
        end else begin
          r = data_reply();
        end
      end else begin
        r.action = ACT_ERROR;
        r.error_kind = ERR_RETRIES;
        close_session();
      end
    end else if (ev.func == FUNC_ERROR) begin
      r.action = ACT_PEER_ABORT;
      close_session();
    end else if (ev.ack == 16'd0) begin
      // ack 0 only matters while the option ack is outstanding
      if (opt_phase) begin
        opt_phase = 1'b0;
        cut_block();
        r = data_reply();
      end
    end else if (opt_phase) begin
      r.action = ACT_ERROR;
      r.error_kind = ERR_WRONG_ACK;
      close_session();
    end else if ({1'b0, ev.ack} == blk_ctr) begin
      if (blk_len < bsize) begin
        r.action = ACT_DONE;
        close_session();
      end else begin
        blk_offset = blk_offset + {16'd0, blk_len};
        blk_ctr = blk_ctr + 17'd1;
        cut_block();
        r = data_reply();
      end
    end else if ({1'b0, ev.ack} == blk_ctr - 17'd1) begin
      r = data_reply();
    end else begin
      r.action = ACT_ERROR;
      r.error_kind = ERR_WRONG_ACK;
      close_session();
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("reply %0d: %s got %0h expected %0h", replies_seen, what, got, want);
  endtask

  // stimulus
  task automatic add_event(logic [2:0] f, logic [15:0] ack);
    xfer_ev_t ev;
    ev.func = f;
    ev.ack = ack;
    ev.flen = $urandom();
    ev.opt = 1'($urandom_range(0, 1));
    events_to_send.push_back(ev);
    events_queued++;
  endtask

  task automatic add_start(logic [31:0] flen, logic opt);
    xfer_ev_t ev;
    ev.func = FUNC_START;
    ev.ack = 16'($urandom());
    ev.flen = flen;
    ev.opt = opt;
    events_to_send.push_back(ev);
    events_queued++;
  endtask

  // a mostly well-behaved client session with random disturbances
  task automatic add_session();
    int unsigned flen, nblk, k, pick;
    logic opt;
    opt = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 1) flen = $urandom();
    else if (pick < 3) flen = bsize * $urandom_range(0, 4);
    else flen = $urandom_range(0, bsize * 5 + 7);
    add_start(flen, opt);
    if (opt) begin
      if ($urandom_range(0, 4) == 0) add_event(FUNC_TIMEOUT, 16'($urandom()));
      if ($urandom_range(0, 14) == 0) begin
        add_event(FUNC_ACK, 16'($urandom_range(1, 65535)));
        return;
      end
      add_event(FUNC_ACK, 16'd0);
    end
    nblk = (bsize == 0) ? 6 : flen / bsize + 1;
    if (nblk > 10) nblk = $urandom_range(3, 10);
    for (k = 1; k <= nblk; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        add_event(FUNC_TIMEOUT, 16'($urandom()));
      end else if (pick < 25 && k > 1) begin
        add_event(FUNC_ACK, 16'(k - 1));
      end else if (pick < 28) begin
        add_event(FUNC_ACK, 16'd0);
      end else if (pick < 31) begin
        add_event(3'($urandom_range(FUNC_OTHER, FUNC_RESERVED_HI)), 16'($urandom()));
      end else if (pick < 33) begin
        add_event(FUNC_ERROR, 16'($urandom()));
        return;
      end else if (pick < 35) begin
        add_event(FUNC_ACK, 16'($urandom()));
        return;
      end
      add_event(FUNC_ACK, 16'(k));
    end
    if ($urandom_range(0, 3) == 0)
      add_event(3'($urandom_range(FUNC_TIMEOUT, FUNC_RESERVED_HI)), 16'($urandom()));
  endtask

  task automatic add_sessions(int unsigned n);
    int unsigned base;
    base = events_queued;
    while (events_queued - base < n) add_session();
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (events_to_send.size() != 0 || in_flight || sender_replies_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_transfer_regs(logic [15:0] size_val, logic [7:0] limit_val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_BLK_BYTES;
    cfg_data_i <= size_val;
    @(posedge clk_i);
    cfg_idx_i <= CFG_RETRY_LIMIT;
    cfg_data_i <= {8'd0, limit_val};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bsize = size_val;
    rlimit = limit_val;
    settings_used++;
  endtask

  // driver: bursts of transactions separated by random gaps
  xfer_ev_t    cur_ev;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    logic nxt_valid;
    if (rst_ni) begin
      nxt_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        sender_replies_due.push_back(predict_sender_reply(cur_ev));
        events_accepted++;
        in_flight = 1'b0;
        nxt_valid = 1'b0;
      end
      if (!in_flight) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (events_to_send.size() != 0) begin
          cur_ev = events_to_send.pop_front();
          in_flight = 1'b1;
          nxt_valid = 1'b1;
          s_axis_tdata <= {7'd0, cur_ev.opt, cur_ev.flen, cur_ev.ack};
          s_axis_tuser <= cur_ev.func;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
          end else begin
            burst_left--;
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // receiver: ready runs with short stalls in front
  int unsigned ready_left = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (ready_left > 0) begin
        ready_left--;
        m_axis_tready <= 1'b1;
      end else begin
        ready_left = $urandom_range(1, 30);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      replies_seen++;
      action_hits[m_axis_tuser]++;
      if (sender_replies_due.size() == 0) begin
        flag_mismatch("unexpected reply, action", 32'(m_axis_tuser), 32'd0);
      end else begin
        want = sender_replies_due.pop_front();
        if (m_axis_tuser != want.action)
          flag_mismatch("action", 32'(m_axis_tuser), 32'(want.action));
        if (m_axis_tdata[15:0] != want.blk_num)
          flag_mismatch("blk_num", 32'(m_axis_tdata[15:0]), 32'(want.blk_num));
        if (m_axis_tdata[47:16] != want.byte_offset)
          flag_mismatch("byte_offset", m_axis_tdata[47:16], want.byte_offset);
        if (m_axis_tdata[63:48] != want.data_length)
          flag_mismatch("data_length", 32'(m_axis_tdata[63:48]), 32'(want.data_length));
        if (m_axis_tdata[65:64] != want.error_kind)
          flag_mismatch("error_kind", 32'(m_axis_tdata[65:64]), 32'(want.error_kind));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d replies outstanding", sender_replies_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    sess_on = 1'b0;
    opt_phase = 1'b0;
    blk_ctr = 17'd1;
    blk_offset = '0;
    blk_len = '0;
    bytes_left = '0;
    retries = '0;
    bsize = BLK_BYTES_RST;
    rlimit = RETRY_LIMIT_RST;
    events_queued = 0;
    events_accepted = 0;
    replies_seen = 0;
    mismatches = 0;
    settings_used = 1;
    cycles = 0;
    foreach (action_hits[i]) action_hits[i] = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset register values
    add_event(FUNC_TIMEOUT, 16'd1);
    add_event(FUNC_ACK, 16'd1);
    add_event(FUNC_ERROR, 16'd0);
    add_event(FUNC_OTHER, 16'hFFFF);
    add_start(32'd0, 1'b0);
    add_event(FUNC_ACK, 16'd1);
    add_start(32'd1024, 1'b1);
    add_event(FUNC_TIMEOUT, 16'd0);
    add_event(FUNC_ACK, 16'd5);
    add_start(32'd1024, 1'b1);
    add_event(FUNC_ACK, 16'd0);
    add_event(FUNC_ACK, 16'd0);
    add_event(FUNC_ACK, 16'd1);
    add_event(FUNC_TIMEOUT, 16'd0);
    add_event(FUNC_ACK, 16'd1);
    add_event(FUNC_ACK, 16'd2);
    add_event(FUNC_RESERVED_HI, 16'd3);
    add_start(32'hFFFF_FFFF, 1'b0);
    add_event(FUNC_ERROR, 16'd1);
    add_start(32'd600, 1'b0);
    for (k = 0; k < 6; k++) add_event(FUNC_TIMEOUT, 16'd1);
    add_event(FUNC_ACK, 16'd3);
    add_start(32'd100, 1'b0);
    add_event(FUNC_ACK, 16'd9);
    wait_drained();

    set_transfer_regs(16'd8, 8'd0);
    add_sessions(200);
    wait_drained();

    set_transfer_regs(16'd71, 8'd2);
    add_sessions(200);
    // leave a session open across the register change
    add_start(32'd1000, 1'b0);
    add_event(FUNC_ACK, 16'd1);
    add_event(FUNC_ACK, 16'd2);
    wait_drained();

    set_transfer_regs(16'd65464, 8'd255);
    add_event(FUNC_ACK, 16'd3);
    add_sessions(250);
    wait_drained();

    set_transfer_regs(16'($urandom_range(8, 400)), 8'($urandom_range(0, 10)));
    add_sessions(300);
    wait_drained();

    // zero block size: nothing is ever short
    set_transfer_regs(16'd0, 8'd3);
    add_start($urandom(), 1'b0);
    for (k = 1; k <= 40; k++) add_event(FUNC_ACK, 16'(k));
    add_event(FUNC_ACK, 16'd39);
    add_event(FUNC_ACK, 16'd0);
    add_event(FUNC_TIMEOUT, 16'd0);
    add_event(FUNC_ACK, 16'd1);
    add_sessions(30);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (sender_replies_due.size() != 0)
      flag_mismatch("replies never delivered", 32'(sender_replies_due.size()), 32'd0);
    $display("%0d events over %0d register settings, zero block size included",
             events_accepted, settings_used);
    $display("replies: %0d data, %0d oack, %0d error, %0d done, %0d abort, %0d none",
             action_hits[ACT_DATA], action_hits[ACT_OACK], action_hits[ACT_ERROR],
             action_hits[ACT_DONE], action_hits[ACT_PEER_ABORT], action_hits[ACT_NONE]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/tftp_rtc_pkg.sv
rtl/tftp_rtc_in_stage.sv
rtl/tftp_rtc_ctrl.sv
rtl/tftp_rtc_out_stage.sv
rtl/tftp_read_transfer_control.sv
rtl/tftp_rtc_checker.sv
tb/tftp_read_transfer_control_test.sv
